// ===== design/ucp_pkg.sv =====
// shared constants and types for the unit cross product pipeline
`default_nettype none
package ucp_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int OUT_W          = 16;
  localparam int OUT_MAX        = 32767;

  // cross term widths
  localparam int PROD_W  = 2 * COMPONENT_BITS;
  localparam int MAG_W   = 2 * COMPONENT_BITS;
  localparam int SHIFT_W = $clog2(MAG_W + 1);
  // truncated magnitudes stay below 2^31
  localparam int U_W     = 31;
  localparam int SQ_W    = 2 * U_W;
  localparam int SUM_W   = 2 * U_W + 2;
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int R_W     = U_W + 1;

  // division
  localparam int DIVD_W  = R_W + FRACTION_BITS;
  localparam int Q_W     = FRACTION_BITS + 1;
  localparam int STEP_W  = $clog2(Q_W);
  localparam int QS_W    = (Q_W > OUT_W) ? Q_W : OUT_W;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef logic signed [OUT_W-1:0]          ocomp_t;

  // per item side data carried down the pipeline
  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    logic [2:0][U_W-1:0] u;
  } carry_t;

  // square root cell state
  typedef struct packed {
    logic [SUM_W-1:0] v;
    logic [SUM_W-1:0] res;
    carry_t           c;
  } sq_t;

  // division cell state
  typedef struct packed {
    logic [2:0][DIVD_W-1:0] rem;
    logic [2:0][Q_W-1:0]    q;
    logic [R_W-1:0]         r;
    logic [2:0]             neg;
    logic                   degen;
  } div_t;

endpackage
`default_nettype wire

// ===== design/ucp_front.sv =====
// front stages: cross terms, magnitudes, range shift, squares and their sum
`default_nettype none
module ucp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ucp_pkg::comp_t   ax,
  input  wire ucp_pkg::comp_t   ay,
  input  wire ucp_pkg::comp_t   az,
  input  wire ucp_pkg::comp_t   bx,
  input  wire ucp_pkg::comp_t   by,
  input  wire ucp_pkg::comp_t   bz,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ucp_pkg::sq_t          out_data
);
  import ucp_pkg::*;

  logic [4:0] v_r;
  logic [4:0] rdy;

  logic signed [PROD_W-1:0] p_r [0:5];
  logic signed [PROD_W-1:0] p_nxt [0:5];
  logic [2:0][MAG_W-1:0]    mag_r, mag_nxt;
  logic [2:0]               neg1_r, neg2_r, neg3_r, neg4_r, neg_nxt;
  logic                     dg1_r, dg2_r, dg3_r, dg4_r, dg_nxt;
  logic [2:0][U_W-1:0]      u_r, u_nxt, u4_r, u5_r;
  logic [2:0][SQ_W-1:0]     sq_r, sq_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [MAG_W-1:0]         orv;
  logic [SHIFT_W-1:0]       sh;
  logic signed [PROD_W:0]   diff [0:2];

  // stall chain, a stage takes a beat when empty or draining
  always_comb begin
    rdy[4] = ~v_r[4] | out_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = ~v_r[i] | rdy[i+1];
    end
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // six partial products
  always_comb begin
    p_nxt[0] = PROD_W'(ay) * PROD_W'(bz);
    p_nxt[1] = PROD_W'(az) * PROD_W'(by);
    p_nxt[2] = PROD_W'(az) * PROD_W'(bx);
    p_nxt[3] = PROD_W'(ax) * PROD_W'(bz);
    p_nxt[4] = PROD_W'(ax) * PROD_W'(by);
    p_nxt[5] = PROD_W'(ay) * PROD_W'(bx);
  end

  // differences to sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = (PROD_W+1)'(p_r[2*i]) - (PROD_W+1)'(p_r[2*i+1]);
      neg_nxt[i] = diff[i][PROD_W];
      mag_nxt[i] = neg_nxt[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
    end
    dg_nxt = (mag_nxt == '0);
  end

  // shift that brings the largest magnitude under 2^31
  always_comb begin
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    sh  = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i] && i >= U_W) begin
        sh = SHIFT_W'(i - U_W + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = U_W'(mag_r[i] >> sh);
    end
  end

  // squares, then their sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQ_W'(u_r[i]) * SQ_W'(u_r[i]);
    end
    sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
    end
    if (rdy[1] && v_r[0]) begin
      mag_r  <= mag_nxt;
      neg1_r <= neg_nxt;
      dg1_r  <= dg_nxt;
    end
    if (rdy[2] && v_r[1]) begin
      u_r    <= u_nxt;
      neg2_r <= neg1_r;
      dg2_r  <= dg1_r;
    end
    if (rdy[3] && v_r[2]) begin
      sq_r   <= sq_nxt;
      u4_r   <= u_r;
      neg3_r <= neg2_r;
      dg3_r  <= dg2_r;
    end
    if (rdy[4] && v_r[3]) begin
      sum_r  <= sum_nxt;
      u5_r   <= u4_r;
      neg4_r <= neg3_r;
      dg4_r  <= dg3_r;
    end
  end

  assign out_data.v       = sum_r;
  assign out_data.res     = '0;
  assign out_data.c.neg   = neg4_r;
  assign out_data.c.degen = dg4_r;
  assign out_data.c.u     = u5_r;

endmodule
`default_nettype wire

// ===== design/ucp_sqrt_cell.sv =====
// one bit step of the integer square root
`default_nettype none
module ucp_sqrt_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [ucp_pkg::SUM_W-1:0] step_bit,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire ucp_pkg::sq_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ucp_pkg::sq_t                   out_data
);
  import ucp_pkg::*;

  logic             v_r;
  sq_t              d_r, d_nxt;
  logic [SUM_W-1:0] trial;

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // subtract res + bit when it fits
  always_comb begin
    d_nxt = in_data;
    trial = in_data.res + step_bit;
    if (in_data.v >= trial) begin
      d_nxt.v   = in_data.v - trial;
      d_nxt.res = (in_data.res >> 1) + step_bit;
    end else begin
      d_nxt.res = in_data.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ucp_div_cell.sv =====
// one quotient bit of the three parallel divisions by the length
`default_nettype none
module ucp_div_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [ucp_pkg::STEP_W-1:0] step,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ucp_pkg::div_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ucp_pkg::div_t                   out_data
);
  import ucp_pkg::*;

  logic              v_r;
  div_t              d_r, d_nxt;
  logic [DIVD_W-1:0] dsh;

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // restoring step against the shifted divisor, one per lane
  always_comb begin
    d_nxt = in_data;
    dsh   = DIVD_W'(in_data.r) << step;
    for (int i = 0; i < 3; i++) begin
      if (in_data.rem[i] >= dsh) begin
        d_nxt.rem[i] = in_data.rem[i] - dsh;
        d_nxt.q[i]   = in_data.q[i] | (Q_W'(1) << step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/unit_cross_product.sv =====
// stages: 5 front stages, 32 root cells, 1 bias stage, 15 divide cells and 1 output register
// throughput: one vector pair per cycle while out_ready holds; every stage is a register with its own valid bit
// a stage takes a new beat whenever it is empty or its successor takes its beat
// the rate is set by the bit-per-cell root and quotient chains, which never iterate
// reset (rst_n low, synchronous) empties every stage; payload registers are not reset
`default_nettype none
module unit_cross_product (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ucp_pkg::comp_t in_ax,
  input  wire ucp_pkg::comp_t in_ay,
  input  wire ucp_pkg::comp_t in_az,
  input  wire ucp_pkg::comp_t in_bx,
  input  wire ucp_pkg::comp_t in_by,
  input  wire ucp_pkg::comp_t in_bz,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ucp_pkg::ocomp_t     out_nx,
  output ucp_pkg::ocomp_t     out_ny,
  output ucp_pkg::ocomp_t     out_nz,
  output logic                out_degenerate
);
  import ucp_pkg::*;

  sq_t  sq_d   [0:SQ_STEPS];
  logic sq_v   [0:SQ_STEPS];
  logic sq_rdy [0:SQ_STEPS];

  div_t dv_d   [0:Q_W];
  logic dv_v   [0:Q_W];
  logic dv_rdy [0:Q_W];

  logic  bias_v_r, out_v_r;
  div_t  bias_r, bias_nxt;
  logic  out_rdy;
  logic [R_W-1:0] root;
  ocomp_t n_nxt [0:2];
  logic [QS_W-1:0] qx;

  // cross terms through the sum of squares
  ucp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ax        (in_ax),
    .ay        (in_ay),
    .az        (in_az),
    .bx        (in_bx),
    .by        (in_by),
    .bz        (in_bz),
    .out_valid (sq_v[0]),
    .out_ready (sq_rdy[0]),
    .out_data  (sq_d[0])
  );

  // square root chain, highest bit first
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    ucp_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_bit  (SUM_W'(1) << (SUM_W - 2 - 2 * k)),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // rounding bias: dividend = u << frac + r / 2
  assign root          = R_W'(sq_d[SQ_STEPS].res);
  assign sq_rdy[SQ_STEPS] = ~bias_v_r | dv_rdy[0];

  always_comb begin
    bias_nxt.r     = root;
    bias_nxt.neg   = sq_d[SQ_STEPS].c.neg;
    bias_nxt.degen = sq_d[SQ_STEPS].c.degen;
    bias_nxt.q     = '0;
    for (int i = 0; i < 3; i++) begin
      bias_nxt.rem[i] = (DIVD_W'(sq_d[SQ_STEPS].c.u[i]) << FRACTION_BITS)
                        + DIVD_W'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_v_r <= 1'b0;
    end else if (sq_rdy[SQ_STEPS]) begin
      bias_v_r <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[SQ_STEPS] && sq_v[SQ_STEPS]) begin
      bias_r <= bias_nxt;
    end
  end

  assign dv_v[0] = bias_v_r;
  assign dv_d[0] = bias_r;

  // quotient chain, highest bit first
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    ucp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (STEP_W'(Q_W - 1 - j)),
      .in_valid  (dv_v[j]),
      .in_ready  (dv_rdy[j]),
      .in_data   (dv_d[j]),
      .out_valid (dv_v[j+1]),
      .out_ready (dv_rdy[j+1]),
      .out_data  (dv_d[j+1])
    );
  end

  // saturate, apply sign, zero a degenerate beat
  assign out_rdy     = ~out_v_r | out_ready;
  assign dv_rdy[Q_W] = out_rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx = QS_W'(dv_d[Q_W].q[i]);
      if (qx > QS_W'(OUT_MAX)) begin
        qx = QS_W'(OUT_MAX);
      end
      n_nxt[i] = dv_d[Q_W].neg[i] ? -OUT_W'(qx) : OUT_W'(qx);
      if (dv_d[Q_W].degen) begin
        n_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_v[Q_W]) begin
      out_nx         <= n_nxt[0];
      out_ny         <= n_nxt[1];
      out_nz         <= n_nxt[2];
      out_degenerate <= dv_d[Q_W].degen;
    end
  end

  assign out_valid = out_v_r;

  // checks
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
    else $error("degenerate beat with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_nx != '0 || out_ny != '0 || out_nz != '0)
    else $error("zero normal on a nondegenerate beat");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[SQ_STEPS] && !sq_d[SQ_STEPS].c.degen |-> root != '0)
    else $error("zero length for a nonzero cross product");

  // a degenerate beat divides by a zero length, so its quotient is not bounded
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v[Q_W] && !dv_d[Q_W].degen
               |-> dv_d[Q_W].q[0] <= (Q_W'(1) << FRACTION_BITS)
               && dv_d[Q_W].q[1] <= (Q_W'(1) << FRACTION_BITS)
               && dv_d[Q_W].q[2] <= (Q_W'(1) << FRACTION_BITS))
    else $error("quotient above unit length");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the unit cross product pipeline: normal prediction, scoreboard, stimulus
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ucp_pkg::*;

  localparam int RANDOM_PAIRS = 650;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } normal_t;

  int error_count = 0;

  // one mismatch line and a count
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // integer root of a 64-bit value, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // unit normal of a x b in Q1.14
  function automatic normal_t predict_normal(input comp_t ax, ay, az, bx, by, bz);
    normal_t n;
    longint p [3], q [3];
    longint unsigned mag [3], m, total, r, quo;
    logic neg [3];
    logic signed [15:0] comp [3];
    int sh;
    p[0] = longint'(ay) * bz; q[0] = longint'(az) * by;
    p[1] = longint'(az) * bx; q[1] = longint'(ax) * bz;
    p[2] = longint'(ax) * by; q[2] = longint'(ay) * bx;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = p[i] < q[i];
      mag[i] = neg[i] ? longint'(q[i] - p[i]) : longint'(p[i] - q[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1'b1;
      return n;
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      total += mag[i] * mag[i];
    end
    r = int_sqrt(total);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      quo = ((mag[i] << FRACTION_BITS) + (r >> 1)) / r;
      if (quo > OUT_MAX) quo = OUT_MAX;
      comp[i] = neg[i] ? -quo[15:0] : quo[15:0];
    end
    n.nx = comp[0]; n.ny = comp[1]; n.nz = comp[2]; n.degen = 1'b0;
    return n;
  endfunction

  // holds expected normals in order
  class normal_scoreboard;
    normal_t pending [$];
    int checked = 0;
    int degen_seen = 0;

    function void note_pair(comp_t ax, ay, az, bx, by, bz);
      pending.push_back(predict_normal(ax, ay, az, bx, by, bz));
    endfunction

    task check_normal(logic signed [15:0] nx, ny, nz, logic degen);
      normal_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (degen) degen_seen++;
      if (nx !== e.nx) report_mismatch("nx", nx, e.nx);
      if (ny !== e.ny) report_mismatch("ny", ny, e.ny);
      if (nz !== e.nz) report_mismatch("nz", nz, e.nz);
      if (degen !== e.degen) report_mismatch("degenerate", degen, e.degen);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  comp_t in_ax = '0, in_ay = '0, in_az = '0, in_bx = '0, in_by = '0, in_bz = '0;
  logic in_ready, out_valid, out_degenerate;
  ocomp_t out_nx, out_ny, out_nz;

  normal_scoreboard sb = new();
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unit_cross_product uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pair(in_ax, in_ay, in_az, in_bx, in_by, in_bz);
      if (out_valid && out_ready)
        sb.check_normal(out_nx, out_ny, out_nz, out_degenerate);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // receiver stall pattern: phases of always-ready, random, and long stalls
  always @(negedge clk) begin
    int ph;
    ph = ($time / 2000) % 4;
    case (ph)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // present one beat and hold it until accepted
  task automatic send_pair(input comp_t ax, ay, az, bx, by, bz);
    in_ax <= ax; in_ay <= ay; in_az <= az;
    in_bx <= bx; in_by <= by; in_bz <= bz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(16'h8000);
      1: return comp_t'(16'h7fff);
      2: return comp_t'($urandom_range(0, 7) - 4);
      default: return comp_t'($urandom());
    endcase
  endfunction

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    comp_t ax, ay, az, k;
    int burst;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, zero and parallel vectors, axis cases
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1, 2, 3, 0, 0, 0);
    send_pair(1, 2, 3, 2, 4, 6);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(0, 1, 0, 1, 0, 0);
    send_pair(0, 0, 1, 1, 0, 0);
    send_pair(-32768, 0, 0, 0, 32767, 0);
    send_pair(-32768, 32767, -32768, 32767, -32768, 32767);
    send_pair(32767, -32768, 0, -32768, 32767, -32768);
    send_pair(-32768, -32768, 32767, 32767, -32768, -32768);
    send_pair(32767, 32767, 32767, -32768, 32767, -32768);
    send_pair(1, 1, 0, 1, -1, 0);
    send_pair(3, 0, 0, 0, 4, 1);
    send_pair(-1, -1, -1, 1, 0, 0);
    send_pair(16'sh5555, 16'sh2aaa, -16'sh5555, -16'sh2aaa, 16'sh5555, 16'sh1234);
    pause_sender();

    // random: bursts with gaps, some parallel pairs mixed in
    for (int n = 0; n < RANDOM_PAIRS; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < RANDOM_PAIRS; j++, n++) begin
        ax = rand_comp(); ay = rand_comp(); az = rand_comp();
        if ($urandom_range(0, 9) == 0) begin
          k = comp_t'($urandom_range(0, 6) - 3);
          send_pair(ax >>> 2, ay >>> 2, az >>> 2, (ax >>> 2) * k, (ay >>> 2) * k,
                    (az >>> 2) * k);
        end else begin
          send_pair(ax, ay, az, rand_comp(), rand_comp(), rand_comp());
        end
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    // drain, then allow for pipeline latency
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d normals, %0d degenerate, over bursty input and stalled output",
             sb.checked, sb.degen_seen);
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/ucp_pkg.sv
design/ucp_front.sv
design/ucp_sqrt_cell.sv
design/ucp_div_cell.sv
design/unit_cross_product.sv
tb/sv/tb_top.sv
